// ----- hw/rtl/thfd_pkg.sv -----
// Shared types, constants and helper functions for the temperature/humidity
// frame decoder. No dependencies; every other file of the block imports it.
`default_nettype none

package thfd_pkg;

  // CRC-8 over each data word: polynomial x^8 + x^5 + x^4 + 1.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Conversion constants in hundredths; FULL_SCALE is the raw word range.
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [13:0] HUM_SCALE   = 14'd12500;
  localparam logic [15:0] HUM_OFFSET  = 16'd600;
  localparam logic [15:0] HUM_MAX     = 16'd10000;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // Port widths of the streams.
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;

  // Position of the next byte inside the six-byte response.
  typedef enum logic [2:0] {
    POS_A_HI  = 3'd0,
    POS_A_LO  = 3'd1,
    POS_A_CRC = 3'd2,
    POS_B_HI  = 3'd3,
    POS_B_LO  = 3'd4,
    POS_B_CRC = 3'd5
  } pos_t;

  // Frame status codes.
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_FIRST_CRC  = 2'd1,
    STATUS_SECOND_CRC = 2'd2
  } status_t;

  // One completed frame as it travels from front to back.
  typedef struct packed {
    logic [15:0] first_word;
    logic [15:0] second_word;
    status_t     status;
  } frame_t;

  // One byte step of the CRC, MSB first.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 2^32 - 1. With q0 = x >> 16 the remainder
  // is (x mod 2^16) + q0, which stays below twice the divisor, so one
  // compare settles the quotient.
  function automatic logic [15:0] div_full_scale(input logic [31:0] x);
    logic [15:0] q0;
    logic [16:0] rem;
    q0  = x[31:16];
    rem = {1'b0, x[15:0]} + {1'b0, q0};
    if (rem >= FULL_SCALE) begin
      return q0 + 16'd1;
    end
    return q0;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/thfd_front.sv -----
// Front part of the frame decoder: tracks the byte position, runs the CRC,
// assembles both words and hands each completed frame on. Uses thfd_pkg.
`default_nettype none

module thfd_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            byte_valid,
  input  wire logic [7:0]      rx_byte,
  input  wire logic            frame_start,
  output thfd_pkg::frame_t     push_frame,
  output logic                 push
);
  import thfd_pkg::*;

  pos_t        pos_r, pos_nxt, pos_eff;
  logic [7:0]  crc_r, crc_nxt, crc_eff, crc_upd;
  logic [15:0] word_a_r, word_a_nxt;
  logic [15:0] word_b_r, word_b_nxt;
  logic        first_ok_r, first_ok_nxt;

  // A start mark restarts position and CRC for this byte.
  assign pos_eff = frame_start ? POS_A_HI : pos_r;
  assign crc_eff = frame_start ? CRC_INIT : crc_r;
  assign crc_upd = crc8_step(crc_eff, rx_byte);

  // Next position.
  always_comb begin
    pos_nxt = pos_r;
    if (byte_valid) begin
      unique case (pos_eff)
        POS_A_HI:  pos_nxt = POS_A_LO;
        POS_A_LO:  pos_nxt = POS_A_CRC;
        POS_A_CRC: pos_nxt = POS_B_HI;
        POS_B_HI:  pos_nxt = POS_B_LO;
        POS_B_LO:  pos_nxt = POS_B_CRC;
        default:   pos_nxt = POS_A_HI;
      endcase
    end
  end

  // Word assembly, CRC and frame hand-off.
  always_comb begin
    crc_nxt      = crc_r;
    word_a_nxt   = word_a_r;
    word_b_nxt   = word_b_r;
    first_ok_nxt = first_ok_r;
    push         = 1'b0;
    push_frame.first_word  = word_a_r;
    push_frame.second_word = word_b_r;
    if (!first_ok_r) begin
      push_frame.status = STATUS_FIRST_CRC;
    end else if (crc_eff != rx_byte) begin
      push_frame.status = STATUS_SECOND_CRC;
    end else begin
      push_frame.status = STATUS_OK;
    end
    if (byte_valid) begin
      unique case (pos_eff)
        POS_A_HI: begin
          word_a_nxt = {rx_byte, 8'h00};
          crc_nxt    = crc_upd;
        end
        POS_A_LO: begin
          word_a_nxt = {word_a_r[15:8], rx_byte};
          crc_nxt    = crc_upd;
        end
        POS_A_CRC: begin
          first_ok_nxt = (crc_eff == rx_byte);
          crc_nxt      = CRC_INIT;
        end
        POS_B_HI: begin
          word_b_nxt = {rx_byte, 8'h00};
          crc_nxt    = crc_upd;
        end
        POS_B_LO: begin
          word_b_nxt = {word_b_r[15:8], rx_byte};
          crc_nxt    = crc_upd;
        end
        default: begin
          // Second check byte closes the frame.
          push    = 1'b1;
          crc_nxt = CRC_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= POS_A_HI;
      crc_r      <= CRC_INIT;
      word_a_r   <= '0;
      word_b_r   <= '0;
      first_ok_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      word_a_r   <= word_a_nxt;
      word_b_r   <= word_b_nxt;
      first_ok_r <= first_ok_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/thfd_queue.sv -----
// Short frame queue between the front and back parts of the decoder.
// Register storage with a fill count. Uses thfd_pkg for the frame type.
`default_nettype none

module thfd_queue #(
  parameter int DEPTH = thfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  thfd_pkg::frame_t      push_frame,
  output logic                  not_full,
  input  wire logic             pop,
  output logic                  not_empty,
  output thfd_pkg::frame_t      head_frame
);
  import thfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frame_t            mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign not_full   = (count_r != CNT_FULL);
  assign not_empty  = (count_r != '0);
  assign head_frame = mem_r[rd_ptr_r];
  assign do_push    = push && not_full;
  assign do_pop     = pop && not_empty;

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Frame storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/thfd_back.sv -----
// Back part of the frame decoder: scales the raw words to hundredths in a
// two-stage pipeline ending in the output register. Uses thfd_pkg.
`default_nettype none

module thfd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            frame_valid,
  input  thfd_pkg::frame_t     frame,
  output logic                 frame_pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic signed [14:0]   temperature_centi,
  output logic [13:0]          humidity_centi,
  output logic [15:0]          first_word,
  output logic [15:0]          second_word,
  output logic [1:0]           status
);
  import thfd_pkg::*;

  // Product stage.
  logic        s1_valid_r;
  frame_t      s1_frame_r;
  logic [30:0] s1_temp_prod_r;
  logic [29:0] s1_hum_prod_r;
  logic        s1_ready;

  // Output stage.
  logic        s2_valid_r;
  frame_t      s2_frame_r;
  logic [14:0] s2_temp_r, s2_temp_nxt;
  logic [13:0] s2_hum_r, s2_hum_nxt;
  logic        s2_ready;

  logic [15:0] temp_q, hum_q;
  logic [15:0] temp_diff, hum_diff;

  assign s2_ready  = !s2_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign frame_pop = frame_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= frame_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  // Constant multiplications by the full-range spans.
  always_ff @(posedge clk) begin
    if (frame_pop) begin
      s1_frame_r     <= frame;
      s1_temp_prod_r <= 31'(frame.first_word * TEMP_SCALE);
      s1_hum_prod_r  <= 30'(frame.second_word * HUM_SCALE);
    end
  end

  // Division by the word range, offsets, clamp and zeroing on a bad CRC.
  always_comb begin
    temp_q    = div_full_scale({1'b0, s1_temp_prod_r});
    hum_q     = div_full_scale({2'b00, s1_hum_prod_r});
    temp_diff = temp_q - TEMP_OFFSET;
    hum_diff  = hum_q - HUM_OFFSET;
    s2_temp_nxt = temp_diff[14:0];
    if (hum_q < HUM_OFFSET) begin
      s2_hum_nxt = '0;
    end else if (hum_diff > HUM_MAX) begin
      s2_hum_nxt = HUM_MAX[13:0];
    end else begin
      s2_hum_nxt = hum_diff[13:0];
    end
    if (s1_frame_r.status != STATUS_OK) begin
      s2_temp_nxt = '0;
      s2_hum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_frame_r <= s1_frame_r;
      s2_temp_r  <= s2_temp_nxt;
      s2_hum_r   <= s2_hum_nxt;
    end
  end

  assign out_valid         = s2_valid_r;
  assign temperature_centi = signed'(s2_temp_r);
  assign humidity_centi    = s2_hum_r;
  assign first_word        = s2_frame_r.first_word;
  assign second_word       = s2_frame_r.second_word;
  assign status            = s2_frame_r.status;

endmodule

`default_nettype wire

// ----- hw/rtl/temp_humidity_frame_decoder_top.sv -----
// Top level of the temperature/humidity frame decoder: front, frame queue and
// back joined to the byte and result streams. Uses thfd_pkg and all submodules.
//
//   Channel  Direction  tdata (low bit up)                          tuser
//   in_      slave      rx_byte[7:0]                                frame_start
//   out_     master     temperature_centi, humidity_centi,          status[1:0]
//                       first_word, second_word, zero pad
//
// One byte is accepted every cycle while in_tready is high; the CRC step is a single byte-wide unit.
// out_tvalid rises once the frame that the sixth byte closes has passed the
// queue entry, written at the edge that takes that byte, the registered constant
// multiplies and the output register holding the scaling, in that order.
// Reset clears position, CRC, queue and pipeline valids; no clearing pass.
// in_tready drops only when the frame queue is full, which needs the output
// to stall for several frames.
`default_nettype none

module temp_humidity_frame_decoder_top #(
  parameter int QUEUE_DEPTH = thfd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Byte stream.
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [thfd_pkg::IN_TDATA_W-1:0]    in_tdata,  // rx_byte[7:0]
  input  wire logic                               in_tuser,  // frame_start
  // Result stream.
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // [14:0] temperature_centi, [28:15] humidity_centi, [44:29] first_word,
  // [60:45] second_word, [63:61] zero
  output logic [thfd_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output logic [1:0]                              out_tuser   // status
);
  import thfd_pkg::*;

  frame_t              push_frame, head_frame;
  logic                push, not_full, not_empty, frame_pop;
  logic                byte_valid;
  logic signed [14:0]  temperature_centi;
  logic [13:0]         humidity_centi;
  logic [15:0]         first_word, second_word;

  assign in_tready  = not_full;
  assign byte_valid = in_tvalid && not_full;

  thfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_valid  (byte_valid),
    .rx_byte     (in_tdata),
    .frame_start (in_tuser),
    .push_frame  (push_frame),
    .push        (push)
  );

  thfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .not_full   (not_full),
    .pop        (frame_pop),
    .not_empty  (not_empty),
    .head_frame (head_frame)
  );

  thfd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .frame_valid       (not_empty),
    .frame             (head_frame),
    .frame_pop         (frame_pop),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .first_word        (first_word),
    .second_word       (second_word),
    .status            (out_tuser)
  );

  // Pack the result word.
  assign out_tdata = {3'b000, second_word, first_word, humidity_centi,
                      unsigned'(temperature_centi)};

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking bench for temp_humidity_frame_decoder_top: it streams response
// bytes in, predicts each decoded frame, and checks the results in order.
// Depends on thfd_pkg and the RTL top level only.
`timescale 1ns / 100ps

package tb_thfd_pkg;
  import thfd_pkg::*;

  // One decoded frame, as it is expected on the result stream.
  typedef struct {
    logic signed [14:0] temperature;
    logic [13:0]        humidity;
    logic [15:0]        first_word;
    logic [15:0]        second_word;
    status_t            status;
  } reading_t;

  class frame_scoreboard;
    pos_t        position;
    logic [7:0]  crc;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic        first_ok;
    reading_t    readings_due[$];
    int          mismatches;
    int          frames_checked;
    int          status_seen[3];

    function new();
      position = POS_A_HI;
      crc      = CRC_INIT;
      word_a   = '0;
      word_b   = '0;
      first_ok = 1'b0;
      mismatches     = 0;
      frames_checked = 0;
      status_seen    = '{0, 0, 0};
    endfunction

    // MSB-first CRC-8 update over one byte.
    static function logic [7:0] crc_next(logic [7:0] crc_in, logic [7:0] data);
      logic [7:0] c;
      c = crc_in ^ data;
      for (int i = 0; i < 8; i++) begin
        c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
    endfunction

    static function logic [7:0] crc_of_word(logic [15:0] w);
      return crc_next(crc_next(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    function int pending();
      return readings_due.size();
    endfunction

    // Advance the decode state by one accepted byte; a sixth byte queues a reading.
    function void take_byte(logic [7:0] b, logic start);
      reading_t r;
      longint   t;
      longint   h;
      status_t  st;
      // A start mark always restarts the frame and drops any partial one.
      if (start) begin
        position = POS_A_HI;
        crc      = CRC_INIT;
      end
      case (position)
        POS_A_HI: begin
          word_a   = {b, 8'h00};
          crc      = crc_next(crc, b);
          position = POS_A_LO;
        end
        POS_A_LO: begin
          word_a[7:0] = b;
          crc         = crc_next(crc, b);
          position    = POS_A_CRC;
        end
        POS_A_CRC: begin
          first_ok = (crc == b);
          crc      = CRC_INIT;
          position = POS_B_HI;
        end
        POS_B_HI: begin
          word_b   = {b, 8'h00};
          crc      = crc_next(crc, b);
          position = POS_B_LO;
        end
        POS_B_LO: begin
          word_b[7:0] = b;
          crc         = crc_next(crc, b);
          position    = POS_B_CRC;
        end
        default: begin
          // The first mismatch wins when both checks fail.
          if (!first_ok) st = STATUS_FIRST_CRC;
          else if (crc != b) st = STATUS_SECOND_CRC;
          else st = STATUS_OK;
          t = 0;
          h = 0;
          if (st == STATUS_OK) begin
            t = -4500 + (longint'(word_a) * 17500) / 65535;
            h = -600 + (longint'(word_b) * 12500) / 65535;
            if (h < 0) h = 0;
            if (h > 10000) h = 10000;
          end
          r.temperature = t[14:0];
          r.humidity    = h[13:0];
          r.first_word  = word_a;
          r.second_word = word_b;
          r.status      = st;
          readings_due.push_back(r);
          position = POS_A_HI;
          crc      = CRC_INIT;
        end
      endcase
    endfunction

    // Compare one accepted result word with the oldest expected reading.
    function void check_result(logic [63:0] data, logic [1:0] user);
      reading_t want;
      logic     bad;
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: tdata=%h tuser=%0d", $time, data, user);
        return;
      end
      want = readings_due.pop_front();
      frames_checked++;
      status_seen[want.status]++;
      bad = (data[14:0] !== want.temperature) || (data[28:15] !== want.humidity) ||
            (data[44:29] !== want.first_word) || (data[60:45] !== want.second_word) ||
            (data[63:61] !== 3'b000) || (user !== want.status);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] frame mismatch: expected temp=%0d hum=%0d w1=%h w2=%h status=%0d",
                   $time, want.temperature, want.humidity, want.first_word,
                   want.second_word, want.status);
          $display("[%0t]                 actual temp=%0d hum=%0d w1=%h w2=%h status=%0d pad=%b",
                   $time, $signed(data[14:0]), data[28:15], data[44:29], data[60:45],
                   user, data[63:61]);
        end
      end
    endfunction
  endclass

endpackage

module tb_top;
  import thfd_pkg::*;
  import tb_thfd_pkg::*;

  localparam int ITEMS     = 750;
  localparam int LIMIT     = 250000;
  localparam int HOLD_LONG = 400;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_EVERY_THIRD, RX_SPARSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  frame_scoreboard sb = new();

  int       bytes_sent = 0;
  int       burst_left = 0;
  int       cycles = 0;
  bit       hold_request = 1'b0;
  int       hold_left = 0;
  int       rx_phase = 0;
  int       rx_tick = 0;
  rx_mode_t rx_mode = RX_OPEN;

  temp_humidity_frame_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // rx_byte[7:0]
    .in_tuser   (in_tuser),   // frame_start
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // temperature, humidity, first word, second word, pad
    .out_tuser  (out_tuser)   // status
  );

  always #6 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check accepted words, then pick the next ready value.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (hold_request) begin
      hold_left    = HOLD_LONG;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_mode  = rx_mode_t'($urandom_range(0, 3));
        rx_phase = $urandom_range(16, 96);
      end else begin
        rx_phase--;
      end
      case (rx_mode)
        RX_OPEN:        out_tready <= 1'b1;
        RX_MOSTLY:      out_tready <= ($urandom_range(0, 3) != 0);
        RX_EVERY_THIRD: out_tready <= (rx_tick % 3 == 0);
        default:        out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
    rx_tick++;
  end

  // Offer one byte and hold it until accepted; bursts end in a random gap.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    sb.take_byte(b, start);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 20);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Send the first n bytes of a response; flips corrupt the check bytes.
  task automatic send_frame(input logic [15:0] a, input logic [15:0] b,
                            input logic [7:0] flip_a, input logic [7:0] flip_b,
                            input logic mark, input int n);
    logic [7:0] bytes[6];
    bytes[0] = a[15:8];
    bytes[1] = a[7:0];
    bytes[2] = frame_scoreboard::crc_of_word(a) ^ flip_a;
    bytes[3] = b[15:8];
    bytes[4] = b[7:0];
    bytes[5] = frame_scoreboard::crc_of_word(b) ^ flip_b;
    for (int i = 0; i < n; i++) send_byte(bytes[i], (i == 0) ? mark : 1'b0);
  endtask

  // Hold the input idle until every expected frame has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  // Mostly uniform words, sometimes the range ends and the clamp edges.
  function automatic logic [15:0] pick_word();
    logic [15:0] corners[10] = '{16'h0000, 16'h0001, 16'hFFFF, 16'hFFFE, 16'h8000,
                                 16'h7FFF, 16'd3145, 16'd3152, 16'd55575, 16'd55576};
    if ($urandom_range(0, 5) == 0) return corners[$urandom_range(0, 9)];
    return 16'($urandom());
  endfunction

  initial begin
    int       r;
    int       n;
    bit       held = 1'b0;
    bit       paused = 1'b0;
    logic [7:0] fa;
    logic [7:0] fb;
    int       errors;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: scale ends with the humidity clamps, a frame without a
    // start mark after a completed one, both checks wrong, and a restart
    // just before the last byte followed by a second-check failure.
    send_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 1'b1, 6);
    send_frame(16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b0, 6);
    send_frame(16'h6A5C, 16'h93A1, 8'hFF, 8'h01, 1'b1, 6);
    send_frame(16'h1234, 16'h5678, 8'h00, 8'h00, 1'b1, 5);
    send_frame(16'h8000, 16'hC0DE, 8'h00, 8'h80, 1'b1, 6);

    // Random part: mostly well-formed frames, some bad checks, some cut
    // short, and some loose noise bytes.
    while (bytes_sent < ITEMS) begin
      if (!held && bytes_sent >= 300) begin
        held         = 1'b1;
        hold_request = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 78) begin
        send_frame(pick_word(), pick_word(), 8'h00, 8'h00, ($urandom_range(0, 9) != 0), 6);
      end else if (r < 88) begin
        fa = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        fb = (fa == 8'h00 || $urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 255))
                                                         : 8'h00;
        send_frame(pick_word(), pick_word(), fa, fb, 1'b1, 6);
      end else if (r < 95) begin
        send_frame(pick_word(), pick_word(), 8'h00, 8'h00, 1'b1, $urandom_range(1, 5));
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_byte(8'($urandom()), 1'($urandom()));
      end
      if (!paused && bytes_sent >= 520) begin
        paused = 1'b1;
        drain();
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    errors = sb.mismatches + sb.pending();
    $display("Streamed %0d bytes; checked %0d frames (ok %0d, first check bad %0d,",
             bytes_sent, sb.frames_checked, sb.status_seen[STATUS_OK],
             sb.status_seen[STATUS_FIRST_CRC]);
    $display("second check bad %0d). Mismatches: %0d, frames never seen: %0d.",
             sb.status_seen[STATUS_SECOND_CRC], sb.mismatches, sb.pending());
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
